FILE: sv/cid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_pkg
// Shared constants, codes and types of the cluster isolation detector.
// ----------------------------------------------------------------------------
package cid_pkg;

    localparam int MAX_NODES = 16;
    localparam int SLOT_W    = $clog2(MAX_NODES);
    localparam int FILL_W    = $clog2(MAX_NODES + 1);

    localparam int ID_W      = 32;
    localparam int SVC_W     = 32;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 2;
    localparam int TICK_W    = 16;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int FLAG_W    = 3;
    localparam int STATUS_W  = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // topology event kinds
    localparam logic [KIND_W-1:0] KIND_PUBLISHED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WITHDRAWN = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_TYPE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AWAIT_TICKS = 2'd2;

    localparam logic [TICK_W-1:0] AWAIT_TICKS_RESET = 16'd1000;

    // node flag bits
    localparam int FLAG_CTRL = 0;
    localparam int FLAG_ACT  = 1;
    localparam int FLAG_UP   = 2;

    // await timer states
    localparam logic [STATUS_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RUN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXP  = 2'd2;

    typedef struct packed {
        logic full;
        logic act_inc;
        logic act_dec;
        logic cup_inc;
        logic cup_dec;
    } tbl_result_t;

    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [FILL_W-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        if (wide > 32'd31)
        begin
            sat_count = 5'd31;
        end
        else
        begin
            sat_count = wide[CNT_OUT_W-1:0];
        end
    endfunction

endpackage

FILE: sv/cid_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_req_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface cid_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] node_id;
    logic [1:0]  event_kind;
    logic [31:0] service_type;

    modport source (output valid, command, node_id, event_kind, service_type,
                    input ready);
    modport sink   (input valid, command, node_id, event_kind, service_type,
                    output ready);
endinterface

FILE: sv/cid_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_rsp_if
// Result item channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface cid_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] updates_sent;
    logic       isolated;
    logic [4:0] active_count;
    logic [4:0] controller_up_count;
    logic       timer_running;
    logic       table_full;

    modport source (output valid, updates_sent, isolated, active_count,
                    controller_up_count, timer_running, table_full,
                    input ready);
    modport sink   (input valid, updates_sent, isolated, active_count,
                    controller_up_count, timer_running, table_full,
                    output ready);
endinterface

FILE: sv/cid_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_table
// Node table: parallel lookup of the named node, allocation of the lowest
// free slot, flag update, and the resulting change of the running counts.
// ----------------------------------------------------------------------------
module cid_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         evt_en,
    input  logic [cid_pkg::ID_W-1:0]     node_id,
    input  logic [cid_pkg::KIND_W-1:0]   event_kind,
    input  logic [cid_pkg::SVC_W-1:0]    service_type,
    input  logic [cid_pkg::SVC_W-1:0]    ctrl_type,
    input  logic [cid_pkg::SVC_W-1:0]    act_type,
    output cid_pkg::tbl_result_t         result
);
    import cid_pkg::*;

    logic [ID_W-1:0]    node_ids_reg [MAX_NODES];
    logic [FLAG_W-1:0]  flags_reg [MAX_NODES];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    logic [MAX_NODES-1:0] hit;
    logic [SLOT_W-1:0]    hit_slot;
    logic                 any_hit;
    logic                 full;
    logic                 we;
    logic [SLOT_W-1:0]    slot;
    logic [FLAG_W-1:0]    old_flags;
    logic [FLAG_W-1:0]    new_flags;
    logic                 old_cup;
    logic                 new_cup;

    // entries are never freed, so the valid slots are exactly [0, fill)
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            hit[i] = (FILL_W'(i) < fill_reg) && (node_ids_reg[i] == node_id);
            if (hit[i])
            begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    assign any_hit   = |hit;
    assign full      = !any_hit && (fill_reg == FILL_W'(MAX_NODES));
    assign slot      = any_hit ? hit_slot : fill_reg[SLOT_W-1:0];
    assign we        = evt_en && !full;
    assign old_flags = any_hit ? flags_reg[slot] : '0;

    always_comb
    begin
        new_flags = old_flags;
        case (event_kind)
            KIND_PUBLISHED:
            begin
                if (service_type == ctrl_type)
                begin
                    new_flags[FLAG_CTRL] = 1'b1;
                end
                else if (service_type == act_type)
                begin
                    new_flags[FLAG_ACT] = 1'b1;
                end
                else if (service_type == '0)
                begin
                    new_flags[FLAG_UP] = 1'b1;
                end
            end
            KIND_WITHDRAWN:
            begin
                if (service_type == act_type)
                begin
                    new_flags[FLAG_ACT] = 1'b0;
                end
                else if (service_type == '0)
                begin
                    new_flags[FLAG_UP]   = 1'b0;
                    new_flags[FLAG_CTRL] = 1'b0;
                end
            end
            default:
            begin
                new_flags = old_flags;
            end
        endcase
    end

    assign old_cup = old_flags[FLAG_CTRL] && old_flags[FLAG_UP];
    assign new_cup = new_flags[FLAG_CTRL] && new_flags[FLAG_UP];

    always_comb
    begin
        result.full    = evt_en && full;
        result.act_inc = we && !old_flags[FLAG_ACT] && new_flags[FLAG_ACT];
        result.act_dec = we && old_flags[FLAG_ACT] && !new_flags[FLAG_ACT];
        result.cup_inc = we && !old_cup && new_cup;
        result.cup_dec = we && old_cup && !new_cup;
    end

    assign fill_next = (we && !any_hit) ? fill_reg + FILL_W'(1) : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                flags_reg[i] <= '0;
            end
        end
        else
        begin
            fill_reg <= fill_next;
            if (we)
            begin
                flags_reg[slot] <= new_flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && !any_hit)
        begin
            node_ids_reg[slot] <= node_id;
        end
    end

endmodule

FILE: sv/cluster_isolation_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_isolation_detector_top
// Tracks peer nodes from topology events, runs the await-active timer and
// applies the isolation rule after every item, one result per item.
// ----------------------------------------------------------------------------
// Stages: input register, then result register. Throughput: one item per
// cycle while results are taken, set by the combinational table lookup
// and state update; a stalled result holds the input once both stages
// are full.
// Reset: asynchronous active low; clears the node table, counts, timer and
// isolation flag and loads the register defaults; node ids are not cleared.
module cluster_isolation_detector_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cid_pkg::CFG_W-1:0]     cfg_data,
    cid_req_if.sink                       req,
    cid_rsp_if.source                     rsp
);
    import cid_pkg::*;

    // configuration
    logic [SVC_W-1:0]  ctrl_type_reg;
    logic [SVC_W-1:0]  act_type_reg;
    logic [TICK_W-1:0] await_ticks_reg;

    // input stage
    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [SVC_W-1:0]  svc_reg;

    // detector state
    logic [FILL_W-1:0]   act_total_reg;
    logic [FILL_W-1:0]   act_total_next;
    logic [FILL_W-1:0]   cup_total_reg;
    logic [FILL_W-1:0]   cup_total_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [TICK_W-1:0]   counter_reg;
    logic [TICK_W-1:0]   counter_next;
    logic                iso_reg;
    logic                iso_next;

    // result stage
    logic                 out_valid_reg;
    logic [1:0]           upd_reg;
    logic [1:0]           upd_next;
    logic                 iso_out_reg;
    logic [CNT_OUT_W-1:0] act_out_reg;
    logic [CNT_OUT_W-1:0] cup_out_reg;
    logic                 run_out_reg;
    logic                 full_out_reg;

    logic        advance;
    logic        rule_upd;
    tbl_result_t tbl;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    cid_table u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt_en       (advance && (cmd_reg == CMD_EVENT)),
        .node_id      (id_reg),
        .event_kind   (kind_reg),
        .service_type (svc_reg),
        .ctrl_type    (ctrl_type_reg),
        .act_type     (act_type_reg),
        .result       (tbl)
    );

    always_comb
    begin
        act_total_next = act_total_reg + FILL_W'(tbl.act_inc) - FILL_W'(tbl.act_dec);
        cup_total_next = cup_total_reg + FILL_W'(tbl.cup_inc) - FILL_W'(tbl.cup_dec);
    end

    // timer tick, then the isolation rule on the updated counts
    always_comb
    begin
        status_next  = status_reg;
        counter_next = counter_reg;
        iso_next     = iso_reg;
        rule_upd     = 1'b0;

        if ((cmd_reg == CMD_TICK) && (status_reg == ST_RUN))
        begin
            if (counter_reg <= TICK_W'(1))
            begin
                counter_next = '0;
                status_next  = ST_EXP;
            end
            else
            begin
                counter_next = counter_reg - TICK_W'(1);
            end
        end

        if (cup_total_next == '0)
        begin
            status_next = ST_IDLE;
            iso_next    = 1'b1;
            rule_upd    = 1'b1;
        end
        else if (act_total_next == '0)
        begin
            case (status_next)
                ST_RUN:
                begin
                    rule_upd = 1'b0;
                end
                ST_EXP:
                begin
                    iso_next    = 1'b1;
                    status_next = ST_IDLE;
                    rule_upd    = 1'b1;
                end
                default:
                begin
                    status_next  = ST_RUN;
                    counter_next = await_ticks_reg;
                end
            endcase
        end
        else
        begin
            status_next = ST_IDLE;
            iso_next    = (act_total_next != FILL_W'(1));
            rule_upd    = 1'b1;
        end

        upd_next = 2'(rule_upd) + 2'((cmd_reg == CMD_CHECK) && iso_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_type_reg   <= '0;
            act_type_reg    <= '0;
            await_ticks_reg <= AWAIT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CTRL_TYPE:   ctrl_type_reg   <= cfg_data[SVC_W-1:0];
                REG_ACTIVE_TYPE: act_type_reg    <= cfg_data[SVC_W-1:0];
                REG_AWAIT_TICKS: await_ticks_reg <= cfg_data[TICK_W-1:0];
                default:         ctrl_type_reg   <= ctrl_type_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg  <= req.command;
            id_reg   <= req.node_id;
            kind_reg <= req.event_kind;
            svc_reg  <= req.service_type;
        end
    end

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_total_reg <= '0;
            cup_total_reg <= '0;
            status_reg    <= ST_IDLE;
            counter_reg   <= '0;
            iso_reg       <= 1'b0;
        end
        else if (advance)
        begin
            act_total_reg <= act_total_next;
            cup_total_reg <= cup_total_next;
            status_reg    <= status_next;
            counter_reg   <= counter_next;
            iso_reg       <= iso_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            upd_reg      <= upd_next;
            iso_out_reg  <= iso_next;
            act_out_reg  <= sat_count(act_total_next);
            cup_out_reg  <= sat_count(cup_total_next);
            run_out_reg  <= (status_next == ST_RUN);
            full_out_reg <= tbl.full;
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.updates_sent        = upd_reg;
    assign rsp.isolated            = iso_out_reg;
    assign rsp.active_count        = act_out_reg;
    assign rsp.controller_up_count = cup_out_reg;
    assign rsp.timer_running       = run_out_reg;
    assign rsp.table_full          = full_out_reg;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cluster isolation detector. Drives topology
// events, check expiries and ticks through the request channel, keeps a
// local copy of the node table, await timer and isolation flag to work out
// each status result, and compares every result transfer field by field.
// Runs directed cases, several traffic phases with different register
// settings and stall patterns, and a table overflow case.
// ----------------------------------------------------------------------------
module tb;
    import cid_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int POOL_SIZE   = 12;
    localparam int MAX_GAP     = 40;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0]  CMD_UNKNOWN = 2'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

    typedef struct packed {
        logic [1:0]           updates;
        logic                 isolated;
        logic [CNT_OUT_W-1:0] active;
        logic [CNT_OUT_W-1:0] ctrl_up;
        logic                 timer;
        logic                 full;
    } status_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cid_req_if req_ch();
    cid_rsp_if rsp_ch();

    cluster_isolation_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // local copy of the block state
    logic [ID_W-1:0]     node_addr  [MAX_NODES];
    logic                node_known [MAX_NODES];
    logic [FLAG_W-1:0]   node_bits  [MAX_NODES];
    logic [STATUS_W-1:0] await_state;
    logic [TICK_W-1:0]   await_left;
    logic                isolated_now;
    logic [SVC_W-1:0]    ctrl_svc;
    logic [SVC_W-1:0]    active_svc;
    logic [TICK_W-1:0]   await_len;

    status_t         pending_status[$];
    logic [ID_W-1:0] node_pool[POOL_SIZE];
    int              mismatches;
    int              cycle_count;
    int              sender_idle_pct;
    int              receiver_stall_pct;

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Update the local state for one accepted item and return its status.
    function automatic status_t predict_status(input logic [CMD_W-1:0] cmd,
                                               input logic [ID_W-1:0] id,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [SVC_W-1:0] svc);
        int      slot;
        int      act_n;
        int      cup_n;
        status_t res;

        res = '0;
        slot = -1;
        if (cmd == CMD_EVENT)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                if (node_known[i] && node_addr[i] == id)
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                for (int i = MAX_NODES - 1; i >= 0; i--)
                begin
                    if (!node_known[i])
                    begin
                        slot = i;
                    end
                end
                if (slot >= 0)
                begin
                    node_known[slot] = 1'b1;
                    node_addr[slot] = id;
                    node_bits[slot] = '0;
                end
            end
            if (slot < 0)
            begin
                res.full = 1'b1;
            end
            else if (kind == KIND_PUBLISHED)
            begin
                if (svc == ctrl_svc)
                    node_bits[slot][FLAG_CTRL] = 1'b1;
                else if (svc == active_svc)
                    node_bits[slot][FLAG_ACT] = 1'b1;
                else if (svc == '0)
                    node_bits[slot][FLAG_UP] = 1'b1;
            end
            else if (kind == KIND_WITHDRAWN)
            begin
                if (svc == active_svc)
                begin
                    node_bits[slot][FLAG_ACT] = 1'b0;
                end
                else if (svc == '0)
                begin
                    node_bits[slot][FLAG_UP] = 1'b0;
                    node_bits[slot][FLAG_CTRL] = 1'b0;
                end
            end
        end
        else if (cmd == CMD_CHECK)
        begin
            if (isolated_now)
                res.updates = res.updates + 2'd1;
        end
        else if (cmd == CMD_TICK)
        begin
            if (await_state == ST_RUN)
            begin
                if (await_left <= 1)
                begin
                    await_left = '0;
                    await_state = ST_EXP;
                end
                else
                begin
                    await_left = await_left - 1'b1;
                end
            end
        end

        act_n = 0;
        cup_n = 0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (node_known[i])
            begin
                if (node_bits[i][FLAG_ACT])
                    act_n++;
                if (node_bits[i][FLAG_CTRL] && node_bits[i][FLAG_UP])
                    cup_n++;
            end
        end

        // isolation rule on exact counts
        if (cup_n == 0)
        begin
            await_state = ST_IDLE;
            isolated_now = 1'b1;
            res.updates = res.updates + 2'd1;
        end
        else if (act_n == 0)
        begin
            if (await_state == ST_EXP)
            begin
                isolated_now = 1'b1;
                await_state = ST_IDLE;
                res.updates = res.updates + 2'd1;
            end
            else if (await_state != ST_RUN)
            begin
                await_state = ST_RUN;
                await_left = await_len;
            end
        end
        else
        begin
            await_state = ST_IDLE;
            isolated_now = (act_n != 1);
            res.updates = res.updates + 2'd1;
        end

        res.isolated = isolated_now;
        res.active = (act_n > 31) ? 5'd31 : act_n[CNT_OUT_W-1:0];
        res.ctrl_up = (cup_n > 31) ? 5'd31 : cup_n[CNT_OUT_W-1:0];
        res.timer = (await_state == ST_RUN);
        return res;
    endfunction

    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_status.size() == 0)
            begin
                report_mismatch("result with nothing pending", 1, 0);
            end
            else
            begin
                want = pending_status.pop_front();
                if (rsp_ch.updates_sent !== want.updates)
                    report_mismatch("updates_sent", rsp_ch.updates_sent, want.updates);
                if (rsp_ch.isolated !== want.isolated)
                    report_mismatch("isolated", rsp_ch.isolated, want.isolated);
                if (rsp_ch.active_count !== want.active)
                    report_mismatch("active_count", rsp_ch.active_count, want.active);
                if (rsp_ch.controller_up_count !== want.ctrl_up)
                    report_mismatch("controller_up_count", rsp_ch.controller_up_count,
                                    want.ctrl_up);
                if (rsp_ch.timer_running !== want.timer)
                    report_mismatch("timer_running", rsp_ch.timer_running, want.timer);
                if (rsp_ch.table_full !== want.full)
                    report_mismatch("table_full", rsp_ch.table_full, want.full);
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [KIND_W-1:0] kind, input logic [SVC_W-1:0] svc);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.node_id      <= id;
        req_ch.event_kind   <= kind;
        req_ch.service_type <= svc;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_status.push_back(predict_status(cmd, id, kind, svc));
    endtask

    // Hold the sender until every pending status has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_CTRL_TYPE:   ctrl_svc = data;
            REG_ACTIVE_TYPE: active_svc = data;
            REG_AWAIT_TICKS: await_len = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [SVC_W-1:0] ctrl, input logic [SVC_W-1:0] act,
                             input logic [TICK_W-1:0] ticks);
        hold_until_drained();
        write_reg(REG_CTRL_TYPE, ctrl);
        write_reg(REG_ACTIVE_TYPE, act);
        write_reg(REG_AWAIT_TICKS, {{(CFG_W-TICK_W){1'b0}}, ticks});
    endtask

    task automatic test_reset_defaults();
        send_item(CMD_CHECK, $urandom, KIND_OTHER, $urandom);
        send_item(CMD_UNKNOWN, $urandom, KIND_SPARE, $urandom);
        send_item(CMD_TICK, $urandom, KIND_WITHDRAWN, $urandom);
    endtask

    task automatic test_directed_events();
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
        node_a = node_pool[0];
        node_b = node_pool[1];
        configure(32'hFFFF_FFFF, 32'h0000_0001, 16'd3);
        send_item(CMD_EVENT, node_a, KIND_PUBLISHED, 32'h0);
        send_item(CMD_EVENT, node_a, KIND_PUBLISHED, 32'hFFFF_FFFF);
        // count down the await timer to expiry
        repeat (3) send_item(CMD_TICK, $urandom, KIND_W'($urandom), $urandom);
        send_item(CMD_EVENT, node_a, KIND_PUBLISHED, 32'h1);
        send_item(CMD_EVENT, node_b, KIND_PUBLISHED, 32'h0);
        send_item(CMD_EVENT, node_b, KIND_PUBLISHED, 32'hFFFF_FFFF);
        send_item(CMD_EVENT, node_b, KIND_PUBLISHED, 32'h1);
        // split brain plus check expiry: two updates
        send_item(CMD_CHECK, $urandom, KIND_W'($urandom), $urandom);
        send_item(CMD_EVENT, node_b, KIND_WITHDRAWN, 32'h1);
        send_item(CMD_EVENT, node_a, KIND_WITHDRAWN, 32'hFFFF_FFFF);
        send_item(CMD_EVENT, node_a, KIND_WITHDRAWN, 32'h0);
        send_item(CMD_EVENT, $urandom, KIND_OTHER, $urandom);
        send_item(CMD_EVENT, $urandom, KIND_SPARE, 32'h1);
        send_item(CMD_UNKNOWN, $urandom, KIND_W'($urandom), $urandom);
        send_item(CMD_EVENT, node_b, KIND_WITHDRAWN, 32'h0);
        send_item(CMD_TICK, $urandom, KIND_W'($urandom), $urandom);
    endtask

    task automatic run_traffic(input int count, input logic [SVC_W-1:0] ctrl,
                               input logic [SVC_W-1:0] act, input logic [TICK_W-1:0] ticks,
                               input int idle_pct, input int stall_pct);
        int               pick;
        logic [CMD_W-1:0]  cmd;
        logic [KIND_W-1:0] kind;
        logic [SVC_W-1:0]  svc;
        configure(ctrl, act, ticks);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                hold_until_drained();
            pick = $urandom_range(99);
            if (pick < 55)
                cmd = CMD_EVENT;
            else if (pick < 65)
                cmd = CMD_CHECK;
            else if (pick < 95)
                cmd = CMD_TICK;
            else
                cmd = CMD_UNKNOWN;
            pick = $urandom_range(99);
            if (pick < 45)
                kind = KIND_PUBLISHED;
            else if (pick < 80)
                kind = KIND_WITHDRAWN;
            else if (pick < 95)
                kind = KIND_OTHER;
            else
                kind = KIND_SPARE;
            pick = $urandom_range(99);
            if (pick < 30)
                svc = ctrl_svc;
            else if (pick < 60)
                svc = active_svc;
            else if (pick < 85)
                svc = '0;
            else
                svc = $urandom;
            if (cmd == CMD_EVENT)
                send_item(cmd, node_pool[$urandom_range(POOL_SIZE - 1)], kind, svc);
            else
                send_item(cmd, $urandom, KIND_W'($urandom), $urandom);
        end
    endtask

    task automatic test_steady_traffic();
        run_traffic(100, $urandom, $urandom, 16'd4, 0, 0);
    endtask

    task automatic test_sparse_sender();
        run_traffic(100, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 85, 0);
    endtask

    task automatic test_slow_receiver();
        // a zero length expires on the first tick
        run_traffic(100, 32'hFFFF_FFFF, 32'h0000_0000, 16'd0, 0, 85);
    endtask

    task automatic test_mixed_stalls();
        run_traffic(100, $urandom, $urandom, 16'd1, 19, 19);
    endtask

    task automatic test_table_overflow();
        // fresh nodes fill the free slots, then get dropped
        for (int n = 0; n < 20; n++)
            send_item(CMD_EVENT, $urandom, KIND_W'($urandom_range(2)),
                      $urandom_range(1) ? 32'h0 : ctrl_svc);
        for (int n = 0; n < 4; n++)
            send_item(CMD_EVENT, node_pool[$urandom_range(POOL_SIZE - 1)], KIND_PUBLISHED,
                      active_svc);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.command = '0;
        req_ch.node_id = '0;
        req_ch.event_kind = '0;
        req_ch.service_type = '0;
        rsp_ch.ready = 1'b1;
        mismatches = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            node_addr[i] = '0;
            node_known[i] = 1'b0;
            node_bits[i] = '0;
        end
        await_state = ST_IDLE;
        await_left = '0;
        isolated_now = 1'b0;
        ctrl_svc = '0;
        active_svc = '0;
        await_len = AWAIT_TICKS_RESET;
        node_pool[0] = 32'h0000_0000;
        node_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            node_pool[i] = $urandom;

        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_events();
        test_steady_traffic();
        test_sparse_sender();
        test_slow_receiver();
        test_mixed_stalls();
        test_table_overflow();

        hold_until_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: files.f
sv/cid_pkg.sv
sv/cid_req_if.sv
sv/cid_rsp_if.sv
sv/cid_table.sv
sv/cluster_isolation_detector_top.sv
test/tb.sv
